### rtl/ocfp_pkg.sv
package ocfp_pkg;

    localparam int CHANNELS             = 8;
    localparam int CHAN_W               = 3;
    localparam int CHAN_AW              = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NOMINAL_VOLTAGE_CODE = 2048;
    localparam int MS_PER_S             = 1000;

    localparam int KIND_W    = 3;
    localparam int SAMPLE_W  = 12;
    localparam int STATE_W   = 2;
    localparam int FAULT_W   = 3;
    localparam int RETRY_W   = 8;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int DELAY_W   = 18;

    // Request kinds
    localparam logic [KIND_W-1:0] REQ_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] REQ_CURRENT = 3'd1;
    localparam logic [KIND_W-1:0] REQ_VOLTAGE = 3'd2;
    localparam logic [KIND_W-1:0] REQ_EVAL    = 3'd3;
    localparam logic [KIND_W-1:0] REQ_RESET   = 3'd4;
    localparam logic [KIND_W-1:0] REQ_CLR_RTY = 3'd5;

    // Output states
    localparam logic [STATE_W-1:0] ST_DISABLED = 2'd0;
    localparam logic [STATE_W-1:0] ST_FAULT    = 2'd1;
    localparam logic [STATE_W-1:0] ST_WAITING  = 2'd2;
    localparam logic [STATE_W-1:0] ST_OK       = 2'd3;

    // Fault codes
    localparam logic [FAULT_W-1:0] FC_NONE         = 3'd0;
    localparam logic [FAULT_W-1:0] FC_INRUSH       = 3'd1;
    localparam logic [FAULT_W-1:0] FC_OVERCURRENT  = 3'd2;
    localparam logic [FAULT_W-1:0] FC_OVERVOLTAGE  = 3'd3;
    localparam logic [FAULT_W-1:0] FC_UNDERVOLTAGE = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_EN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_EN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INRUSH_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY = 3'd7;

    typedef struct packed {
        logic [STATE_W-1:0]  state;
        logic [FAULT_W-1:0]  fault;
        logic                inrush_active;
        logic [SAMPLE_W-1:0] last_current;
        logic [SAMPLE_W-1:0] last_voltage;
        logic [SAMPLE_W-1:0] peak;
        logic [TIME_W-1:0]   inrush_start;
        logic [RETRY_W-1:0]  retries;
        logic [TIME_W-1:0]   retry_start;
    } chan_rec_t;

    localparam int REC_W = $bits(chan_rec_t);

    localparam chan_rec_t REC_RESET = '{
        state:         ST_OK,
        fault:         FC_NONE,
        inrush_active: 1'b0,
        last_current:  '0,
        last_voltage:  SAMPLE_W'(NOMINAL_VOLTAGE_CODE),
        peak:          '0,
        inrush_start:  '0,
        retries:       '0,
        retry_start:   '0
    };

endpackage

### rtl/ocfp_ram.sv
module ocfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/output_channel_fault_protection_core.sv
// A transaction is registered first into the record stage, and its result is then registered into the output stage.
// Throughput: one transaction per cycle; the channel record is read from an
// eight-entry RAM, updated and written back, with the last write-back forwarded.
// A result held by out_stall keeps the record stage full and so stalls the input.
// Reset: asynchronous, clears control state and the time counter and sets configuration to its defaults;
// a per-channel valid bit makes every record read as its reset value until rewritten.
module output_channel_fault_protection_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ocfp_pkg::KIND_W-1:0]    req_type,
    input  logic [ocfp_pkg::CHAN_W-1:0]    channel,
    input  logic [ocfp_pkg::SAMPLE_W-1:0]  sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ocfp_pkg::CHAN_W-1:0]    out_channel,
    output logic [ocfp_pkg::STATE_W-1:0]   out_state,
    output logic [ocfp_pkg::FAULT_W-1:0]   fault_code,
    output logic [ocfp_pkg::SAMPLE_W-1:0]  out_peak,
    output logic [ocfp_pkg::RETRY_W-1:0]   retry_count,
    input  logic                           cfg_we,
    input  logic [ocfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ocfp_pkg::CFG_W-1:0]     cfg_data
);

    import ocfp_pkg::*;

    // Configuration
    logic [CHANNELS-1:0] chan_en_reg;
    logic [CHANNELS-1:0] retry_en_reg;
    logic [SAMPLE_W-1:0] cur_limit_reg;
    logic [15:0]         inrush_ms_reg;
    logic [SAMPLE_W-1:0] max_volt_reg;
    logic [SAMPLE_W-1:0] min_volt_reg;
    logic [RETRY_W-1:0]  retry_limit_reg;
    logic [DELAY_W-1:0]  retry_delay_ms_reg;

    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   time_next;

    logic                s1_valid_reg;
    logic [KIND_W-1:0]   s1_kind_reg;
    logic [CHAN_W-1:0]   s1_chan_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;

    logic                byp_valid_reg;
    logic [CHAN_W-1:0]   byp_chan_reg;
    chan_rec_t           byp_rec_reg;

    logic [CHANNELS-1:0] ent_valid_reg;

    logic                out_valid_reg;
    logic [CHAN_W-1:0]   out_chan_reg;
    logic [STATE_W-1:0]  out_state_reg;
    logic [FAULT_W-1:0]  out_fault_reg;
    logic [SAMPLE_W-1:0] out_peak_reg;
    logic [RETRY_W-1:0]  out_retry_reg;

    logic                in_accept;
    logic                s1_advance;
    logic                s1_chan_ok;
    logic [CHAN_AW-1:0]  s1_addr;
    logic [REC_W-1:0]    ram_rdata;
    chan_rec_t           cur_rec;
    chan_rec_t           rec_next;
    logic                wr_en;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;
    assign s1_chan_ok = ({1'b0, s1_chan_reg} < (CHAN_W + 1)'(CHANNELS));
    assign s1_addr    = s1_chan_reg[CHAN_AW-1:0];
    assign wr_en      = s1_advance && s1_chan_ok;

    ocfp_ram #(
        .WIDTH (REC_W),
        .DEPTH (CHANNELS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr),
        .wdata (rec_next),
        .re    (in_accept),
        .raddr (channel[CHAN_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_en_reg        <= '0;
            retry_en_reg       <= '0;
            cur_limit_reg      <= SAMPLE_W'(4095);
            inrush_ms_reg      <= 16'd100;
            max_volt_reg       <= SAMPLE_W'(4095);
            min_volt_reg       <= '0;
            retry_limit_reg    <= RETRY_W'(3);
            retry_delay_ms_reg <= DELAY_W'(MS_PER_S);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHAN_EN:     chan_en_reg     <= cfg_data[CHANNELS-1:0];
                CFG_RETRY_EN:    retry_en_reg    <= cfg_data[CHANNELS-1:0];
                CFG_CUR_LIMIT:   cur_limit_reg   <= cfg_data[SAMPLE_W-1:0];
                CFG_INRUSH_MS:   inrush_ms_reg   <= cfg_data;
                CFG_MAX_VOLT:    max_volt_reg    <= cfg_data[SAMPLE_W-1:0];
                CFG_MIN_VOLT:    min_volt_reg    <= cfg_data[SAMPLE_W-1:0];
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[RETRY_W-1:0];
                CFG_RETRY_DELAY: retry_delay_ms_reg <=
                    DELAY_W'({10'd0, cfg_data[7:0]} * DELAY_W'(MS_PER_S));
                default: ;
            endcase
        end
    end

    // The forwarded copy always holds the newest write of its channel, so it may be
    // used whether or not the RAM read already saw that write.
    always_comb
    begin
        if (byp_valid_reg && (byp_chan_reg == s1_chan_reg))
        begin
            cur_rec = byp_rec_reg;
        end
        else if (s1_chan_ok && ent_valid_reg[s1_addr])
        begin
            cur_rec = chan_rec_t'(ram_rdata);
        end
        else
        begin
            cur_rec = REC_RESET;
        end
    end

    always_comb
    begin
        logic [FAULT_W-1:0] f;
        logic [TIME_W-1:0]  inrush_elapsed;
        logic [TIME_W-1:0]  retry_elapsed;
        rec_next       = cur_rec;
        time_next      = time_reg;
        f              = FC_NONE;
        inrush_elapsed = time_reg - cur_rec.inrush_start;
        retry_elapsed  = time_reg - cur_rec.retry_start;
        case (s1_kind_reg)
            REQ_TICK:
            begin
                time_next = time_reg + TIME_W'(1);
            end
            REQ_CURRENT:
            begin
                rec_next.last_current = s1_sample_reg;
                if (s1_sample_reg > cur_rec.peak)
                begin
                    rec_next.peak = s1_sample_reg;
                end
            end
            REQ_VOLTAGE:
            begin
                rec_next.last_voltage = s1_sample_reg;
            end
            REQ_EVAL:
            begin
                if (cur_rec.last_current > cur_limit_reg)
                begin
                    if (cur_rec.fault != FC_NONE && cur_rec.fault != FC_INRUSH)
                    begin
                        f = FC_OVERCURRENT;
                    end
                    else if (cur_rec.inrush_active)
                    begin
                        f = (inrush_elapsed > {16'd0, inrush_ms_reg}) ?
                            FC_OVERCURRENT : FC_INRUSH;
                    end
                    else
                    begin
                        rec_next.inrush_start = time_reg;
                        f = FC_INRUSH;
                    end
                end
                else
                begin
                    rec_next.inrush_start = '0;
                    if (cur_rec.last_voltage > max_volt_reg)
                    begin
                        f = FC_OVERVOLTAGE;
                    end
                    else if (cur_rec.last_voltage < min_volt_reg)
                    begin
                        f = FC_UNDERVOLTAGE;
                    end
                end
                rec_next.fault = f;
                if (f == FC_INRUSH)
                begin
                    rec_next.inrush_active = 1'b1;
                end
                else if (f == FC_OVERCURRENT || f == FC_NONE)
                begin
                    rec_next.inrush_active = 1'b0;
                end
                // Only a latched fault (not inrush) goes through the retry sequence.
                if (!chan_en_reg[s1_addr])
                begin
                    rec_next.state = ST_DISABLED;
                end
                else if (f == FC_NONE || f == FC_INRUSH)
                begin
                    rec_next.state = ST_OK;
                end
                else if (!retry_en_reg[s1_addr] || cur_rec.retries >= retry_limit_reg)
                begin
                    rec_next.state = ST_FAULT;
                end
                else if (cur_rec.state != ST_WAITING)
                begin
                    rec_next.retry_start = time_reg;
                    rec_next.state       = ST_WAITING;
                end
                else if (retry_elapsed < {{(TIME_W-DELAY_W){1'b0}}, retry_delay_ms_reg})
                begin
                    rec_next.state = ST_WAITING;
                end
                else
                begin
                    if (cur_rec.retries != '1)
                    begin
                        rec_next.retries = cur_rec.retries + RETRY_W'(1);
                    end
                    rec_next.retry_start = '0;
                    rec_next.fault       = FC_NONE;
                    rec_next.state       = ST_OK;
                end
            end
            REQ_RESET:
            begin
                rec_next = REC_RESET;
            end
            REQ_CLR_RTY:
            begin
                rec_next.retries = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            ent_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                time_reg      <= time_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                byp_valid_reg          <= 1'b1;
                ent_valid_reg[s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg   <= req_type;
            s1_chan_reg   <= channel;
            s1_sample_reg <= sample;
        end
        if (wr_en)
        begin
            byp_chan_reg <= s1_chan_reg;
            byp_rec_reg  <= rec_next;
        end
        if (s1_advance)
        begin
            out_chan_reg <= s1_chan_reg;
            if (s1_chan_ok)
            begin
                out_state_reg <= rec_next.state;
                out_fault_reg <= rec_next.fault;
                out_peak_reg  <= rec_next.peak;
                out_retry_reg <= rec_next.retries;
            end
            else
            begin
                out_state_reg <= '0;
                out_fault_reg <= '0;
                out_peak_reg  <= '0;
                out_retry_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_chan_reg;
    assign out_state   = out_state_reg;
    assign fault_code  = out_fault_reg;
    assign out_peak    = out_peak_reg;
    assign retry_count = out_retry_reg;

endmodule
